@@ hw/rtl/aia_pkg.sv @@
// Shared types, operation codes and the control store for the accumulator ALU.
// Used by aia_mul, aia_div and accumulator_integer_alu_top; depends on nothing.
package aia_pkg;

	// Default operand width and the multiplier slice handled per cycle
	localparam int DATA_WIDTH = 32;
	localparam int MUL_CHUNK  = 16;

	// Operation codes carried in the low bits of s_tuser
	localparam logic [2:0] OP_ADD = 3'd0;
	localparam logic [2:0] OP_SUB = 3'd1;
	localparam logic [2:0] OP_MUL = 3'd2;
	localparam logic [2:0] OP_DIV = 3'd3;
	localparam logic [2:0] OP_REM = 3'd4;
	localparam logic [2:0] OP_POW = 3'd5;

	// Datapath action of one control word; it takes effect when the step completes
	typedef enum logic [3:0] {
		A_NONE,
		A_SIMPLE,
		A_MUL_START_AB,
		A_MUL_TAKE,
		A_POW_INIT,
		A_POW_DONE,
		A_POW_ACC_START,
		A_POW_ACC_TAKE,
		A_POW_SQ_START,
		A_POW_SQ_TAKE,
		A_DIV_START,
		A_DIV_TAKE,
		A_EMIT
	} act_t;

	// Conditions a control word can test, for holding the step or for a jump
	typedef enum logic [3:0] {
		C_NEVER,
		C_ALWAYS,
		C_NO_ITEM,
		C_OP_SIMPLE,
		C_OP_DIVREM,
		C_OP_POW,
		C_MUL_BUSY,
		C_DIV_BUSY,
		C_EXP_ZERO,
		C_EXP_LSB_CLR,
		C_OUT_FULL
	} cond_t;

	localparam int UPC_W = 4;

	typedef struct packed {
		act_t              act;
		cond_t             hold_c;
		cond_t             jump_c;
		logic [UPC_W-1:0]  target;
	} uword_t;

	// Step addresses of the microprogram
	localparam logic [UPC_W-1:0] UPC_IDLE = UPC_W'(0);
	localparam logic [UPC_W-1:0] UPC_DEC0 = UPC_W'(1);
	localparam logic [UPC_W-1:0] UPC_DEC1 = UPC_W'(2);
	localparam logic [UPC_W-1:0] UPC_DEC2 = UPC_W'(3);
	localparam logic [UPC_W-1:0] UPC_MULS = UPC_W'(4);
	localparam logic [UPC_W-1:0] UPC_MULW = UPC_W'(5);
	localparam logic [UPC_W-1:0] UPC_PTST = UPC_W'(6);
	localparam logic [UPC_W-1:0] UPC_PBIT = UPC_W'(7);
	localparam logic [UPC_W-1:0] UPC_PMS  = UPC_W'(8);
	localparam logic [UPC_W-1:0] UPC_PMW  = UPC_W'(9);
	localparam logic [UPC_W-1:0] UPC_PSS  = UPC_W'(10);
	localparam logic [UPC_W-1:0] UPC_PSW  = UPC_W'(11);
	localparam logic [UPC_W-1:0] UPC_DIVS = UPC_W'(12);
	localparam logic [UPC_W-1:0] UPC_DIVW = UPC_W'(13);
	localparam logic [UPC_W-1:0] UPC_EMIT = UPC_W'(14);

	function automatic uword_t uword(input act_t act, input cond_t hold_c,
			input cond_t jump_c, input logic [UPC_W-1:0] target);
		uword_t w;
		w.act    = act;
		w.hold_c = hold_c;
		w.jump_c = jump_c;
		w.target = target;
		return w;
	endfunction

	// Control store: hold while hold_c, else jump to target on jump_c, else step on
	function automatic uword_t ucode_rom(input logic [UPC_W-1:0] upc);
		uword_t w;
		case (upc)
			UPC_IDLE: w = uword(A_NONE,          C_NO_ITEM,  C_NEVER,       UPC_IDLE);
			UPC_DEC0: w = uword(A_SIMPLE,        C_NEVER,    C_OP_SIMPLE,   UPC_EMIT);
			UPC_DEC1: w = uword(A_NONE,          C_NEVER,    C_OP_DIVREM,   UPC_DIVS);
			UPC_DEC2: w = uword(A_POW_INIT,      C_NEVER,    C_OP_POW,      UPC_PTST);
			UPC_MULS: w = uword(A_MUL_START_AB,  C_NEVER,    C_NEVER,       UPC_IDLE);
			UPC_MULW: w = uword(A_MUL_TAKE,      C_MUL_BUSY, C_ALWAYS,      UPC_EMIT);
			UPC_PTST: w = uword(A_POW_DONE,      C_NEVER,    C_EXP_ZERO,    UPC_EMIT);
			UPC_PBIT: w = uword(A_NONE,          C_NEVER,    C_EXP_LSB_CLR, UPC_PSS);
			UPC_PMS:  w = uword(A_POW_ACC_START, C_NEVER,    C_NEVER,       UPC_IDLE);
			UPC_PMW:  w = uword(A_POW_ACC_TAKE,  C_MUL_BUSY, C_NEVER,       UPC_IDLE);
			UPC_PSS:  w = uword(A_POW_SQ_START,  C_NEVER,    C_NEVER,       UPC_IDLE);
			UPC_PSW:  w = uword(A_POW_SQ_TAKE,   C_MUL_BUSY, C_ALWAYS,      UPC_PTST);
			UPC_DIVS: w = uword(A_DIV_START,     C_NEVER,    C_NEVER,       UPC_IDLE);
			UPC_DIVW: w = uword(A_DIV_TAKE,      C_DIV_BUSY, C_ALWAYS,      UPC_EMIT);
			UPC_EMIT: w = uword(A_EMIT,          C_OUT_FULL, C_ALWAYS,      UPC_IDLE);
			default:  w = uword(A_NONE,          C_NEVER,    C_ALWAYS,      UPC_IDLE);
		endcase
		return w;
	endfunction

endpackage

@@ hw/rtl/aia_mul.sv @@
// Iterative multiplier: low DATA_WIDTH bits of x * y, one slice of y per cycle.
// Depends on aia_pkg for the default width and the slice width.
module aia_mul #(
	parameter int DATA_WIDTH = aia_pkg::DATA_WIDTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [DATA_WIDTH-1:0] x,
	input  logic [DATA_WIDTH-1:0] y,
	output logic                  busy,
	output logic [DATA_WIDTH-1:0] product
);

	localparam int CH    = (DATA_WIDTH < aia_pkg::MUL_CHUNK) ? DATA_WIDTH : aia_pkg::MUL_CHUNK;
	localparam int NCH   = (DATA_WIDTH + CH - 1) / CH;
	localparam int CNT_W = $clog2(NCH + 1);
	localparam int PP_W  = DATA_WIDTH + CH;

	logic [DATA_WIDTH-1:0] mcand_q;
	logic [DATA_WIDTH-1:0] mplier_q;
	logic [DATA_WIDTH-1:0] prod_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [PP_W-1:0]       partial;

	// One partial product of the shifted multiplicand and the current slice
	assign partial = PP_W'(mcand_q) * PP_W'(mplier_q[CH-1:0]);

	// Slice counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(NCH);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// Accumulate partial products, advance to the next slice
	always_ff @(posedge clk) begin
		if (start) begin
			mcand_q  <= x;
			mplier_q <= y;
			prod_q   <= '0;
		end else if (cnt_q != '0) begin
			prod_q   <= prod_q + partial[DATA_WIDTH-1:0];
			mcand_q  <= mcand_q << CH;
			mplier_q <= mplier_q >> CH;
		end
	end

	assign busy    = (cnt_q != '0);
	assign product = prod_q;

endmodule

@@ hw/rtl/aia_div.sv @@
// Restoring divider on unsigned magnitudes: one quotient bit per cycle.
// Depends on aia_pkg for the default width.
module aia_div #(
	parameter int DATA_WIDTH = aia_pkg::DATA_WIDTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [DATA_WIDTH-1:0] dividend,
	input  logic [DATA_WIDTH-1:0] divisor,
	output logic                  busy,
	output logic [DATA_WIDTH-1:0] quotient,
	output logic [DATA_WIDTH-1:0] remainder
);

	localparam int CNT_W = $clog2(DATA_WIDTH + 1);

	logic [DATA_WIDTH-1:0] rem_q;
	logic [DATA_WIDTH-1:0] quo_q;
	logic [DATA_WIDTH-1:0] dsr_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [DATA_WIDTH-1:0] trial;
	logic [DATA_WIDTH:0]   diff;

	// Shift in the next dividend bit and try the subtraction
	assign trial = {rem_q[DATA_WIDTH-2:0], quo_q[DATA_WIDTH-1]};
	assign diff  = {1'b0, trial} - {1'b0, dsr_q};

	// Bit counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(DATA_WIDTH);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// Keep the difference when it did not borrow, else restore
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (cnt_q != '0) begin
			if (!diff[DATA_WIDTH]) begin
				rem_q <= diff[DATA_WIDTH-1:0];
				quo_q <= {quo_q[DATA_WIDTH-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[DATA_WIDTH-2:0], 1'b0};
			end
		end
	end

	assign busy      = (cnt_q != '0);
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

@@ hw/rtl/accumulator_integer_alu_top.sv @@
// Accumulator ALU: microcoded sequencer over a shared multiplier and bit-serial divider.
// Add, sub and unknown codes go from decode straight to emit; mul and div/rem wait on the
// shared multiplier or the divider, and power squares and multiplies per exponent bit.
// One item at a time: s_tready is high only at the idle step, so a new beat is taken only
// once the emit step of the last item has completed.
// arst_n clears the step counter, the output valid flag and the accumulator to zero.
module accumulator_integer_alu_top #(
	parameter int DATA_WIDTH = aia_pkg::DATA_WIDTH
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_tvalid,
	output logic                     s_tready,
	// s_tdata: left_value, right_value, zero padding
	input  logic [((2*DATA_WIDTH+7)/8)*8-1:0] s_tdata,
	// s_tuser: operation [2:0], chain [3]
	input  logic [3:0]               s_tuser,
	output logic                     m_tvalid,
	input  logic                     m_tready,
	// m_tdata: result, zero padding
	output logic [((DATA_WIDTH+7)/8)*8-1:0] m_tdata,
	// m_tuser: divide_error
	output logic [0:0]               m_tuser
);

	localparam int W     = DATA_WIDTH;
	localparam int OUT_W = ((DATA_WIDTH + 7) / 8) * 8;

	logic [aia_pkg::UPC_W-1:0] upc_q;
	logic [aia_pkg::UPC_W-1:0] upc_next;
	aia_pkg::uword_t           uw;
	logic                      hold_hit;
	logic                      jump_hit;
	logic                      act_en;
	logic                      in_fire;

	logic [2:0]   op_q;
	logic [W-1:0] a_q;
	logic [W-1:0] b_q;
	logic [W-1:0] res_q;
	logic         err_q;
	logic [W-1:0] last_q;
	logic [W-1:0] acc_q;
	logic [W-1:0] sq_q;
	logic [W-1:0] exp_q;
	logic         out_valid_q;
	logic [W-1:0] out_result_q;
	logic         out_err_q;

	logic         mul_start;
	logic [W-1:0] mul_x;
	logic [W-1:0] mul_y;
	logic         mul_busy;
	logic [W-1:0] mul_prod;
	logic         div_start;
	logic         div_busy;
	logic [W-1:0] div_quo;
	logic [W-1:0] div_rem;
	logic [W-1:0] a_mag;
	logic [W-1:0] b_mag;

	function automatic logic cond_met(input aia_pkg::cond_t c, input logic [2:0] op,
			input logic item, input logic mbusy, input logic dbusy,
			input logic [W-1:0] expo, input logic ofull);
		logic r;
		case (c)
			aia_pkg::C_NEVER:       r = 1'b0;
			aia_pkg::C_ALWAYS:      r = 1'b1;
			aia_pkg::C_NO_ITEM:     r = !item;
			aia_pkg::C_OP_SIMPLE:   r = !(op inside {aia_pkg::OP_MUL, aia_pkg::OP_DIV,
			                                         aia_pkg::OP_REM, aia_pkg::OP_POW});
			aia_pkg::C_OP_DIVREM:   r = (op inside {aia_pkg::OP_DIV, aia_pkg::OP_REM});
			aia_pkg::C_OP_POW:      r = (op == aia_pkg::OP_POW);
			aia_pkg::C_MUL_BUSY:    r = mbusy;
			aia_pkg::C_DIV_BUSY:    r = dbusy;
			aia_pkg::C_EXP_ZERO:    r = (expo == '0);
			aia_pkg::C_EXP_LSB_CLR: r = !expo[0];
			aia_pkg::C_OUT_FULL:    r = ofull;
			default:                r = 1'b0;
		endcase
		return r;
	endfunction

	// Fetch the control word and work out the next step
	always_comb begin
		uw       = aia_pkg::ucode_rom(upc_q);
		hold_hit = cond_met(uw.hold_c, op_q, s_tvalid, mul_busy, div_busy, exp_q,
		                    out_valid_q && !m_tready);
		jump_hit = cond_met(uw.jump_c, op_q, s_tvalid, mul_busy, div_busy, exp_q,
		                    out_valid_q && !m_tready);
		act_en   = !hold_hit;
		if (hold_hit) begin
			upc_next = upc_q;
		end else if (jump_hit) begin
			upc_next = uw.target;
		end else begin
			upc_next = upc_q + 1'b1;
		end
	end

	assign s_tready = (upc_q == aia_pkg::UPC_IDLE);
	assign in_fire  = s_tvalid && s_tready;

	// Step counter, output valid flag and the accumulator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q       <= aia_pkg::UPC_IDLE;
			out_valid_q <= 1'b0;
			last_q      <= '0;
		end else begin
			upc_q <= upc_next;
			if (act_en && uw.act == aia_pkg::A_EMIT) begin
				out_valid_q <= 1'b1;
				last_q      <= res_q;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Operand magnitudes for the divider
	assign a_mag = a_q[W-1] ? -a_q : a_q;
	assign b_mag = b_q[W-1] ? -b_q : b_q;

	// Multiplier operand selection and start strobes
	always_comb begin
		case (uw.act)
			aia_pkg::A_POW_ACC_START: begin
				mul_x = acc_q;
				mul_y = sq_q;
			end
			aia_pkg::A_POW_SQ_START: begin
				mul_x = sq_q;
				mul_y = sq_q;
			end
			default: begin
				mul_x = a_q;
				mul_y = b_q;
			end
		endcase
		mul_start = act_en && (uw.act inside {aia_pkg::A_MUL_START_AB,
		                                      aia_pkg::A_POW_ACC_START,
		                                      aia_pkg::A_POW_SQ_START});
		div_start = act_en && (uw.act == aia_pkg::A_DIV_START);
	end

	// Latch the beat, then run the datapath actions of completed steps
	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_q <= s_tuser[2:0];
			a_q  <= s_tuser[3] ? last_q : s_tdata[W-1:0];
			b_q  <= s_tdata[2*W-1:W];
		end
		if (act_en) begin
			case (uw.act)
				aia_pkg::A_SIMPLE: begin
					err_q <= 1'b0;
					case (op_q)
						aia_pkg::OP_ADD: res_q <= a_q + b_q;
						aia_pkg::OP_SUB: res_q <= a_q - b_q;
						default:         res_q <= last_q;
					endcase
				end
				aia_pkg::A_MUL_TAKE: begin
					res_q <= mul_prod;
					err_q <= 1'b0;
				end
				aia_pkg::A_POW_INIT: begin
					acc_q <= W'(1);
					sq_q  <= a_q;
					exp_q <= b_q[W-1] ? '0 : b_q;
				end
				aia_pkg::A_POW_DONE: begin
					res_q <= acc_q;
					err_q <= 1'b0;
				end
				aia_pkg::A_POW_ACC_TAKE: acc_q <= mul_prod;
				aia_pkg::A_POW_SQ_TAKE: begin
					sq_q  <= mul_prod;
					exp_q <= exp_q >> 1;
				end
				aia_pkg::A_DIV_TAKE: begin
					if (b_q == '0) begin
						res_q <= last_q;
						err_q <= 1'b1;
					end else begin
						err_q <= 1'b0;
						if (op_q == aia_pkg::OP_DIV) begin
							res_q <= (a_q[W-1] ^ b_q[W-1]) ? -div_quo : div_quo;
						end else begin
							res_q <= a_q[W-1] ? -div_rem : div_rem;
						end
					end
				end
				aia_pkg::A_EMIT: begin
					out_result_q <= res_q;
					out_err_q    <= err_q;
				end
				default: ;
			endcase
		end
	end

	aia_mul #(
		.DATA_WIDTH(DATA_WIDTH)
	) u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.x       (mul_x),
		.y       (mul_y),
		.busy    (mul_busy),
		.product (mul_prod)
	);

	aia_div #(
		.DATA_WIDTH(DATA_WIDTH)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (a_mag),
		.divisor   (b_mag),
		.busy      (div_busy),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// Output beat
	assign m_tvalid   = out_valid_q;
	assign m_tdata    = OUT_W'(out_result_q);
	assign m_tuser[0] = out_err_q;

endmodule
